### sv/aabo_pkg.sv
// Shared widths, register indexes and constants of the box outline pixel core.
package aabo_pkg;

  localparam int ROW_W      = 10;
  localparam int VAL_W      = 16;
  localparam int COORD_W    = 20;
  localparam int HW_W       = 16;
  localparam int INV_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int COV_W      = 17;
  localparam int IMAGE_SIZE = 1024;

  localparam logic [COV_W-1:0] COV_ONE = COV_W'(65536);

  localparam logic [HW_W-1:0]  HW_RESET  = HW_W'(256);
  localparam logic [INV_W-1:0] INV_RESET = INV_W'(65536);
  localparam logic [VAL_W-1:0] INT_RESET = VAL_W'(65535);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_X         = 3'd0,
    CFG_TOP_Y          = 3'd1,
    CFG_RIGHT_X        = 3'd2,
    CFG_BOTTOM_Y       = 3'd3,
    CFG_HALF_WIDTH     = 3'd4,
    CFG_INV_HALF_WIDTH = 3'd5,
    CFG_LINE_INTENSITY = 3'd6,
    CFG_ASYM_SHIFT     = 3'd7
  } cfg_idx_e;

endpackage

### sv/aabo_pix_in_if.sv
// Input pixel channel: valid/ready handshake with row, column and prior value.
interface aabo_pix_in_if
  import aabo_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] pixel_row;
  logic [ROW_W-1:0] pixel_col;
  logic [VAL_W-1:0] prior_value;

  modport source (output valid, output pixel_row, output pixel_col, output prior_value,
                  input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, input prior_value,
                  output ready);
endinterface

### sv/aabo_pix_out_if.sv
// Output pixel channel: valid/ready handshake with the new pixel value.
interface aabo_pix_out_if
  import aabo_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] new_value;

  modport source (output valid, output new_value, input ready);
  modport sink   (input valid, input new_value, output ready);
endinterface

### sv/aabo_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
interface aabo_cfg_if
  import aabo_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/antialiased_box_outline_pixel_core.sv
// Anti-aliased rectangle outline drawn onto a stream of pixels.
//
// pix_i carries one pixel word (row, column, prior value) per handshake;
// pix_o returns one word with the new value for every accepted pixel, in
// order. cfg_i writes the box edges, half width, reciprocal, intensity and
// asymmetry shift; it is always ready. The user must write it only while no
// pixel is in flight; the block itself does not enforce this.
//
// Throughput is one pixel per cycle while pix_o does not stall. A result
// reaches pix_o through four register stages: edge distances and spans,
// the distance times reciprocal multipliers, the intensity times coverage
// multipliers, and the final maximum into the output register.
//
// Each stage carries its own valid bit and advances when it is empty or the
// next stage moves, so a stalled receiver fills the pipeline bubble by
// bubble before pix_i.ready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the register reset values.
module antialiased_box_outline_pixel_core
  import aabo_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aabo_pix_in_if.sink   pix_i,
  aabo_pix_out_if.source pix_o,
  aabo_cfg_if.sink      cfg_i
);

  localparam int XW   = ROW_W + COORD_FRAC_BITS;
  localparam int CW   = (XW + 2 > 23) ? XW + 2 : 23;
  localparam int PW   = HW_W + INV_W;
  localparam int SUBW = PW - COORD_FRAC_BITS;

  // configuration registers
  logic signed [COORD_W-1:0] left_q, top_q, right_q, bottom_q, asym_q;
  logic [HW_W-1:0]           hw_q;
  logic [INV_W-1:0]          inv_q;
  logic [VAL_W-1:0]          int_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= '0;
      bottom_q <= '0;
      hw_q     <= HW_RESET;
      inv_q    <= INV_RESET;
      int_q    <= INT_RESET;
      asym_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_LEFT_X:         left_q   <= signed'(cfg_i.data[COORD_W-1:0]);
        CFG_TOP_Y:          top_q    <= signed'(cfg_i.data[COORD_W-1:0]);
        CFG_RIGHT_X:        right_q  <= signed'(cfg_i.data[COORD_W-1:0]);
        CFG_BOTTOM_Y:       bottom_q <= signed'(cfg_i.data[COORD_W-1:0]);
        CFG_HALF_WIDTH:     hw_q     <= cfg_i.data[HW_W-1:0];
        CFG_INV_HALF_WIDTH: inv_q    <= cfg_i.data[INV_W-1:0];
        CFG_LINE_INTENSITY: int_q    <= cfg_i.data[VAL_W-1:0];
        CFG_ASYM_SHIFT:     asym_q   <= signed'(cfg_i.data[COORD_W-1:0]);
        default: ;
      endcase
    end
  end

  function automatic logic [CW-1:0] abs_diff(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
    logic signed [CW-1:0] t;
    t = a - b;
    return (t < 0) ? CW'(-t) : CW'(t);
  endfunction

  // stage handshake
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic en1, en2, en3, en4;

  assign en4 = !s4_v_q || pix_o.ready;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;
  assign pix_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q <= pix_i.valid;
      if (en2) s2_v_q <= s1_v_q;
      if (en3) s3_v_q <= s2_v_q;
      if (en4) s4_v_q <= s3_v_q;
    end
  end

  // stage 1: spans and edge distances
  logic signed [CW-1:0] x_s, y_s, lx, ty, rx, by, sh, hw_s;
  logic signed [CW-1:0] bot_edge, right_edge;
  logic                 xspan, yspan, in_img;
  logic [CW-1:0]        gap [4];
  logic [3:0]           app_d;
  logic [3:0]           app1_q;
  logic [HW_W-1:0]      d1_q [4];
  logic [VAL_W-1:0]     prior1_q;

  always_comb begin
    x_s  = signed'(CW'({pix_i.pixel_col, {COORD_FRAC_BITS{1'b0}}}));
    y_s  = signed'(CW'({pix_i.pixel_row, {COORD_FRAC_BITS{1'b0}}}));
    lx   = CW'(left_q);
    ty   = CW'(top_q);
    rx   = CW'(right_q);
    by   = CW'(bottom_q);
    sh   = CW'(asym_q);
    hw_s = signed'(CW'(hw_q));
    bot_edge   = by + sh;
    right_edge = rx + sh;
    xspan  = (x_s >= lx - hw_s) && (x_s <= rx + hw_s);
    yspan  = (y_s >= ty - hw_s) && (y_s <= bot_edge + hw_s);
    in_img = (int'(pix_i.pixel_row) < IMAGE_SIZE) && (int'(pix_i.pixel_col) < IMAGE_SIZE);
    gap[0] = abs_diff(y_s, ty);
    gap[1] = abs_diff(y_s, bot_edge);
    gap[2] = abs_diff(x_s, lx);
    gap[3] = abs_diff(x_s, right_edge);
    for (int i = 0; i < 4; i++) begin
      app_d[i] = in_img && (gap[i] <= CW'(hw_q)) && ((i < 2) ? xspan : yspan);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      prior1_q <= pix_i.prior_value;
      app1_q   <= app_d;
      for (int i = 0; i < 4; i++) d1_q[i] <= gap[i][HW_W-1:0];
    end
  end

  // stage 2: distance times reciprocal
  logic [PW-1:0]    prod2_q [4];
  logic [3:0]       app2_q;
  logic [VAL_W-1:0] prior2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prior2_q <= prior1_q;
      app2_q   <= app1_q;
      for (int i = 0; i < 4; i++) prod2_q[i] <= PW'(d1_q[i]) * PW'(inv_q);
    end
  end

  // stage 3: coverage times intensity
  logic [SUBW-1:0]      sub [4];
  logic [COV_W-1:0]     cov [4];
  logic [2*COV_W-2:0]   vprod [4];
  logic [VAL_W-1:0]     val3_q [4];
  logic [3:0]           app3_q;
  logic [VAL_W-1:0]     prior3_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sub[i]   = prod2_q[i][PW-1:COORD_FRAC_BITS];
      cov[i]   = (sub[i] >= SUBW'(COV_ONE)) ? '0 : COV_ONE - sub[i][COV_W-1:0];
      vprod[i] = (2*COV_W-1)'(int_q) * (2*COV_W-1)'(cov[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      prior3_q <= prior2_q;
      app3_q   <= app2_q;
      for (int i = 0; i < 4; i++) val3_q[i] <= vprod[i][2*VAL_W-1:VAL_W];
    end
  end

  // stage 4: maximum into the output register
  logic [VAL_W-1:0] best;
  logic [VAL_W-1:0] out_q;

  always_comb begin
    best = prior3_q;
    for (int i = 0; i < 4; i++) begin
      if (app3_q[i] && (val3_q[i] > best)) best = val3_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) out_q <= best;
  end

  assign pix_o.valid     = s4_v_q;
  assign pix_o.new_value = out_q;

  // a full, stalled pipeline must not take a word
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s2_v_q && s3_v_q && s4_v_q && !pix_o.ready) |-> !pix_i.ready)
    else $error("input accepted while pipeline full and stalled");

  // stage 1 keeps its word while it cannot advance
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !en2) |=> s1_v_q)
    else $error("stage 1 word dropped during stall");

  // a word leaving stage 3 reaches the output register
  a_s3_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && en4) |=> s4_v_q)
    else $error("stage 3 word lost on the way to the output");

  // edge values never exceed the configured intensity
  a_val_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q |-> ((val3_q[0] <= int_q) && (val3_q[1] <= int_q) &&
                (val3_q[2] <= int_q) && (val3_q[3] <= int_q)))
    else $error("edge value above line intensity");

endmodule
